// ===== hdl/trr_pkg.sv =====
// package for the transport reassembly receiver
// holds the item codes, phase type, frame size and the byte mask helper
// used by transport_reassembly_receiver_unit, no dependencies
`timescale 1ns / 1ps

package trr_pkg;

  localparam int FrameBytes = 8;
  localparam int CountW     = 4;
  localparam int ByteW      = 8;
  localparam int PayloadW   = 64;

  localparam int InDataW  = 80;
  localparam int OutDataW = 88;

  typedef enum logic [1:0] {
    FUNC_ARM    = 2'd0,
    FUNC_SETUP  = 2'd1,
    FUNC_DATA   = 2'd2,
    FUNC_CANCEL = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    PH_READY = 2'd0,
    PH_SETUP = 2'd1,
    PH_DATA  = 2'd2
  } phase_t;

  localparam logic [1:0] REPLY_NONE = 2'd0;
  localparam logic [1:0] REPLY_ACK  = 2'd1;
  localparam logic [1:0] REPLY_NACK = 2'd2;

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_DONE_OK  = 2'd1;
  localparam logic [1:0] EV_DONE_BAD = 2'd2;

  // keep the low n bytes of a frame
  function automatic logic [PayloadW-1:0] byte_mask(input logic [CountW-1:0] n);
    logic [PayloadW-1:0] m;
    m = '0;
    for (int i = 0; i < FrameBytes; i++) begin
      if (CountW'(i) < n) m[i*ByteW +: ByteW] = '1;
    end
    return m;
  endfunction

endpackage

// ===== hdl/transport_reassembly_receiver_unit.sv =====
// transport reassembly receiver: checks arm, setup and data items, handles cancel items and
// emits one result per item; depends on trr_pkg
`timescale 1ns / 1ps
//
// channel | dir | tdata                                  | tuser
// s_*     | in  | arm_size, buffer_present, notify_enable,| func
//         |     | frame_present, frame_len, frame_bytes   |
// m_*     | out | arm_status, reply, write_count,         | -
//         |     | write_offset, write_bytes, event_res,   |
//         |     | phase_now                               |
//
// one item per cycle sustained while m_tready holds; the path from accept to result is
// the input register, then the result register after the check logic
// the transaction state is updated when an item moves to the result register
// a stalled result holds the pipe; s_tready drops only when both stages are full
// rst clears the valid flags and the transaction state

module transport_reassembly_receiver_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // [7:0] arm_size, [8] buffer_present, [9] notify_enable, [10] frame_present,
  // [14:11] frame_len, [78:15] frame_bytes, [79] zero
  input  logic [trr_pkg::InDataW-1:0] s_tdata,
  // [1:0] func
  input  logic [1:0]                  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [0] arm_status, [2:1] reply, [6:3] write_count, [14:7] write_offset,
  // [78:15] write_bytes, [80:79] event_res, [82:81] phase_now, [87:83] zero
  output logic [trr_pkg::OutDataW-1:0] m_tdata
);
  import trr_pkg::*;

  // input register
  logic                   in_valid;
  func_t                  in_func;
  logic [ByteW-1:0]       in_arm_size;
  logic                   in_buffer_present;
  logic                   in_notify_enable;
  logic                   in_frame_present;
  logic [CountW-1:0]      in_frame_len;
  logic [PayloadW-1:0]    in_frame_bytes;

  // transaction state
  phase_t                 phase, phase_next;
  logic [ByteW-1:0]       bytes_left, bytes_left_next;
  logic [ByteW-1:0]       write_position, write_position_next;
  logic                   notify_flag, notify_flag_next;

  // result register
  logic                   out_valid;
  logic [OutDataW-1:0]    out_data, out_data_next;

  logic                   advance;
  logic [CountW-1:0]      expect_len;
  logic                   arm_status;
  logic [1:0]             reply;
  logic [CountW-1:0]      wcount;
  logic [ByteW-1:0]       woff;
  logic [PayloadW-1:0]    wbytes;
  logic [1:0]             ev;
  logic                   abort_tx;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_func           <= func_t'(s_tuser);
      in_arm_size       <= s_tdata[7:0];
      in_buffer_present <= s_tdata[8];
      in_notify_enable  <= s_tdata[9];
      in_frame_present  <= s_tdata[10];
      in_frame_len      <= s_tdata[14:11];
      in_frame_bytes    <= s_tdata[78:15];
    end
  end

  assign expect_len = (bytes_left >= ByteW'(FrameBytes)) ? CountW'(FrameBytes)
                                                         : bytes_left[CountW-1:0];

  always_comb begin
    phase_next          = phase;
    bytes_left_next     = bytes_left;
    write_position_next = write_position;
    notify_flag_next    = notify_flag;
    arm_status = 1'b0;
    reply      = REPLY_NONE;
    wcount     = '0;
    woff       = '0;
    wbytes     = '0;
    ev         = EV_NONE;
    abort_tx   = 1'b0;

    unique case (in_func)
      FUNC_ARM: begin
        if (phase != PH_READY || !in_buffer_present ||
            in_arm_size <= ByteW'(FrameBytes)) begin
          arm_status = 1'b1;
        end else begin
          phase_next          = PH_SETUP;
          bytes_left_next     = in_arm_size;
          write_position_next = '0;
          notify_flag_next    = in_notify_enable;
        end
      end
      FUNC_SETUP: begin
        if (phase != PH_SETUP || !in_frame_present || in_frame_len == '0 ||
            bytes_left != in_frame_bytes[ByteW-1:0]) begin
          abort_tx = 1'b1;
        end else begin
          phase_next = PH_DATA;
          reply      = REPLY_ACK;
        end
      end
      FUNC_DATA: begin
        if (phase != PH_DATA || !in_frame_present || in_frame_len != expect_len) begin
          abort_tx = 1'b1;
        end else begin
          reply               = REPLY_ACK;
          wcount              = expect_len;
          woff                = write_position;
          wbytes              = in_frame_bytes & byte_mask(expect_len);
          bytes_left_next     = bytes_left - {4'b0, expect_len};
          write_position_next = write_position + {4'b0, expect_len};
          // last frame closes the transaction
          if (bytes_left_next == '0) begin
            if (notify_flag) ev = EV_DONE_OK;
            phase_next          = PH_READY;
            bytes_left_next     = '0;
            write_position_next = '0;
            notify_flag_next    = 1'b0;
          end
        end
      end
      FUNC_CANCEL: begin
        phase_next          = PH_READY;
        bytes_left_next     = '0;
        write_position_next = '0;
        notify_flag_next    = 1'b0;
      end
      default: begin
        phase_next = phase;
      end
    endcase

    if (abort_tx) begin
      reply = REPLY_NACK;
      if (notify_flag) ev = EV_DONE_BAD;
      phase_next          = PH_READY;
      bytes_left_next     = '0;
      write_position_next = '0;
      notify_flag_next    = 1'b0;
    end

    out_data_next = {5'b0, phase_next, ev, wbytes, woff, wcount, reply, arm_status};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      phase          <= PH_READY;
      bytes_left     <= '0;
      write_position <= '0;
      notify_flag    <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        phase          <= phase_next;
        bytes_left     <= bytes_left_next;
        write_position <= write_position_next;
        notify_flag    <= notify_flag_next;
      end
    end
    if (advance && in_valid) begin
      out_data <= out_data_next;
    end
  end

  // data phase always has bytes still to come
  a_data_has_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> bytes_left != '0)
    else $error("data phase with no bytes left");

  // a done event leaves the block ready
  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data[80:79] != EV_NONE |-> out_data[82:81] == PH_READY)
    else $error("completion event without return to ready");

  // buffer writes come only with an ack
  a_write_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data[6:3] != '0 |-> out_data[2:1] == REPLY_ACK)
    else $error("buffer write without ack");

  // the setup phase is entered only by an accepted arm
  a_setup_from_arm: assert property (@(posedge clk) disable iff (rst)
    $rose(phase == PH_SETUP) |-> $past(in_func) == FUNC_ARM)
    else $error("setup phase entered without arm");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_valid)
    else $error("valid flags not cleared by reset");

endmodule
